[rtl/core/pbba_pkg.sv]
// Package for the page block bitmap allocator: sizes, operation codes and types.
package pbba_pkg;
  localparam int MAX_BLOCKS = 1024;
  localparam int WORD_W     = 32;
  localparam int NUM_WORDS  = MAX_BLOCKS / WORD_W;
  localparam int WADDR_W    = $clog2(NUM_WORDS);
  localparam int BIDX_W     = $clog2(MAX_BLOCKS);
  localparam int BIT_W      = $clog2(WORD_W);
  localparam int CNT_W      = 11;
  localparam int SIZE_W     = 7;
  localparam int GOFF_W     = 10;
  localparam int OFF_W      = 10;
  localparam int OP_W       = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [OP_W-1:0] OP_INIT  = 3'd0;
  localparam logic [OP_W-1:0] OP_ALLOC = 3'd1;
  localparam logic [OP_W-1:0] OP_TMARK = 3'd2;
  localparam logic [OP_W-1:0] OP_UNMRK = 3'd3;
  localparam logic [OP_W-1:0] OP_TEST  = 3'd4;
  localparam logic [OP_W-1:0] OP_SWEEP = 3'd5;
  // Unassigned codes: no state change and an all-zero result.
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_SIZE  = 1'd1;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [GOFF_W-1:0] granule_offset;
  } in_item_t;

  typedef struct packed {
    logic              ok;
    logic [BIDX_W-1:0] block_index;
    logic [OFF_W-1:0]  block_offset;
    logic              was_marked;
    logic              page_full;
  } out_item_t;
endpackage

[rtl/core/pbba_if.sv]
// Valid/ready channel interface carrying one payload.
interface pbba_if #(parameter type payload_t = logic);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/pbba_div.sv]
// Restoring divider: one quotient bit per cycle, granule offset by block size.
module pbba_div import pbba_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [GOFF_W-1:0] dividend,
  input  logic [SIZE_W-1:0] divisor,
  output logic              done,
  output logic [GOFF_W-1:0] quotient
);
  localparam int STEP_W = $clog2(GOFF_W + 1);
  logic [GOFF_W-1:0] q_r, q_nxt;
  logic [SIZE_W:0]   rem_r, rem_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic              busy_r, busy_nxt;
  logic [SIZE_W:0]   trial;

  // One shift and subtract per cycle.
  always_comb begin
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    step_nxt = step_r;
    busy_nxt = busy_r;
    trial    = {rem_r[SIZE_W-1:0], q_r[GOFF_W-1]};
    done     = 1'b0;
    if (start) begin
      q_nxt    = dividend;
      rem_nxt  = '0;
      step_nxt = STEP_W'(GOFF_W);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (step_r == '0) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end else begin
        if (trial >= {1'b0, divisor}) begin
          rem_nxt = trial - {1'b0, divisor};
          q_nxt   = {q_r[GOFF_W-2:0], 1'b1};
        end else begin
          rem_nxt = trial;
          q_nxt   = {q_r[GOFF_W-2:0], 1'b0};
        end
        step_nxt = step_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
  end

  assign quotient = q_r;
endmodule

[rtl/core/page_block_bitmap_allocator.sv]
// Top level of the page block bitmap allocator.
//  channel | direction | payload
//  in_     | sink      | operation, granule_offset
//  out_    | source    | ok, block_index, block_offset, was_marked, page_full
//  cfg_    | write     | block_count (0), block_size_granules (1)
// Alloc reads, then checks, each 32-bit bitmap word in turn.
// Sweep walks all 32 words the same way. Init clears all 32 words.
// Mark ops run the divider, then a read and a write of one word.
// After reset both bitmaps are cleared by a pass over all words before input is taken.
// in_ready is low while an item runs or while a result waits on out_ready.
module page_block_bitmap_allocator import pbba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  pbba_if.sink                  in_ch,
  pbba_if.source                out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_WALK  = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_MRD   = 3'd4;
  localparam logic [2:0] S_MWR   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  logic [2:0]         state_r, state_nxt;
  logic [CNT_W-1:0]   count_r;
  logic [SIZE_W-1:0]  size_r;
  logic [WORD_W-1:0]  used_mem [NUM_WORDS];
  logic [WORD_W-1:0]  mark_mem [NUM_WORDS];
  logic [WORD_W-1:0]  used_rd_r, mark_rd_r;
  logic [WADDR_W:0]   waddr_r, waddr_nxt;
  logic               rd_pend_r, rd_pend_nxt;
  logic [OP_W-1:0]    op_r;
  logic [GOFF_W-1:0]  goff_r;
  logic [BIDX_W-1:0]  qidx_r;
  logic               any_r, any_nxt, all_r, all_nxt;
  out_item_t          res_r, res_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               boot_r;
  logic [BIDX_W:0]    usable;
  logic [SIZE_W-1:0]  eff_size;
  logic               div_start, div_done;
  logic               div_go_r;
  logic [GOFF_W-1:0   ] quot;
  logic               used_we, mark_we;
  logic [WORD_W-1:0]  used_wd, mark_wd;
  logic [WADDR_W-1:0] wa, ra, rda;
  logic [WORD_W-1:0]  lane_ok, free_bits;
  logic [BIT_W-1:0]   first_bit;
  logic               found;
  logic [BIDX_W:0]    base_idx;
  logic [BIDX_W-1:0]  alloc_idx;
  logic [16:0]        prod_r;
  logic               in_rng;

  assign usable   = (count_r > CNT_W'(MAX_BLOCKS)) ? (BIDX_W+1)'(MAX_BLOCKS)
                                                   : (BIDX_W+1)'(count_r);
  assign eff_size = (size_r == '0) ? SIZE_W'(1) : size_r;
  assign ra       = waddr_r[WADDR_W-1:0];
  assign wa       = (state_r == S_MWR) ? qidx_r[BIDX_W-1:BIT_W] : ra;
  assign rda      = (state_r == S_MRD) ? qidx_r[BIDX_W-1:BIT_W] : ra;
  assign base_idx = {waddr_r, {BIT_W{1'b0}}};

  // Lanes of the current word that lie below the usable count.
  always_comb begin
    for (int b = 0; b < WORD_W; b++) begin
      lane_ok[b] = ((base_idx + (BIDX_W+1)'(b)) < usable);
    end
    free_bits = ~used_rd_r & lane_ok;
    found     = |free_bits;
    first_bit = '0;
    for (int b = WORD_W - 1; b >= 0; b--) begin
      if (free_bits[b]) first_bit = BIT_W'(b);
    end
  end
  assign alloc_idx = {ra, first_bit};
  assign in_rng    = ((BIDX_W+1)'(qidx_r) < usable) && (quot == qidx_r);

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= CNT_W'(MAX_BLOCKS);
      size_r  <= SIZE_W'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_BLOCK_COUNT: count_r <= cfg_data[CNT_W-1:0];
        REG_BLOCK_SIZE:  size_r  <= cfg_data[SIZE_W-1:0];
        default: ;
      endcase
    end
  end

  pbba_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(goff_r),
    .divisor(eff_size), .done(div_done), .quotient(quot)
  );

  assign in_ch.ready  = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid = out_valid_r;
  assign out_ch.data  = res_r;

  // Sequencer.
  always_comb begin
    state_nxt     = state_r;
    waddr_nxt     = waddr_r;
    rd_pend_nxt   = 1'b0;
    any_nxt       = any_r;
    all_nxt       = all_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    used_we       = 1'b0;
    mark_we       = 1'b0;
    used_wd       = '0;
    mark_wd       = '0;
    unique case (state_r)
      S_CLEAR: begin
        used_we   = 1'b1;
        mark_we   = 1'b1;
        waddr_nxt = waddr_r + 1'b1;
        // The pass after reset returns to idle; an init transaction reports a result.
        if (ra == WADDR_W'(NUM_WORDS - 1)) state_nxt = boot_r ? S_IDLE : S_OUT;
      end
      S_IDLE: begin
        if (in_ch.valid && in_ch.ready) begin
          res_nxt   = '0;
          waddr_nxt = '0;
          any_nxt   = 1'b0;
          all_nxt   = (usable != '0);
          unique case (in_ch.data.operation) inside
            OP_INIT:  state_nxt = S_CLEAR;
            OP_ALLOC, OP_SWEEP: begin
              state_nxt   = S_WALK;
              rd_pend_nxt = 1'b1;
            end
            OP_TMARK, OP_UNMRK, OP_TEST: state_nxt = S_DIV;
            default: state_nxt = S_OUT;
          endcase
        end
      end
      S_WALK: begin
        if (rd_pend_r) begin
          // Registered read of the current word is not yet back.
        end else if (op_r == OP_ALLOC) begin
          if (found) begin
            used_we              = 1'b1;
            used_wd              = used_rd_r | (WORD_W'(1) << first_bit);
            res_nxt.ok           = 1'b1;
            res_nxt.block_index  = alloc_idx;
            state_nxt            = S_MWR;
          end else if (ra == WADDR_W'(NUM_WORDS - 1)) begin
            state_nxt = S_OUT;
          end else begin
            waddr_nxt   = waddr_r + 1'b1;
            rd_pend_nxt = 1'b1;
          end
        end else begin
          used_we = 1'b1;
          mark_we = 1'b1;
          used_wd = mark_rd_r;
          if ((mark_rd_r & lane_ok) != '0) any_nxt = 1'b1;
          if ((~mark_rd_r & lane_ok) != '0) all_nxt = 1'b0;
          if (ra == WADDR_W'(NUM_WORDS - 1)) begin
            res_nxt.ok        = any_nxt;
            res_nxt.page_full = any_nxt && all_nxt;
            state_nxt         = S_OUT;
          end else begin
            waddr_nxt   = waddr_r + 1'b1;
            rd_pend_nxt = 1'b1;
          end
        end
      end
      S_DIV: begin
        if (div_done) state_nxt = S_MRD;
      end
      S_MRD: begin
        res_nxt.block_index = qidx_r;
        state_nxt           = S_MWR;
      end
      S_MWR: begin
        if (op_r == OP_ALLOC) begin
          res_nxt.block_offset = prod_r[OFF_W-1:0];
          state_nxt            = S_OUT;
        end else begin
          if (in_rng) begin
            res_nxt.was_marked = mark_rd_r[qidx_r[BIT_W-1:0]];
            mark_wd            = mark_rd_r;
            if (op_r == OP_TMARK) begin
              mark_we = 1'b1;
              mark_wd[qidx_r[BIT_W-1:0]] = 1'b1;
            end else if (op_r == OP_UNMRK) begin
              mark_we = 1'b1;
              mark_wd[qidx_r[BIT_W-1:0]] = 1'b0;
            end
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Divider is started in the cycle after acceptance of a mark or test operation.
  assign div_start = div_go_r;

  // Bitmap memories: one word written and one word read per cycle.
  always_ff @(posedge clk) begin
    if (used_we) used_mem[wa] <= used_wd;
    if (mark_we) mark_mem[wa] <= mark_wd;
    used_rd_r <= used_mem[rda];
    mark_rd_r <= mark_mem[rda];
  end

  // Control and payload registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      waddr_r     <= '0;
      rd_pend_r   <= 1'b0;
      out_valid_r <= 1'b0;
      div_go_r    <= 1'b0;
      boot_r      <= 1'b1;
    end else begin
      state_r     <= state_nxt;
      waddr_r     <= waddr_nxt;
      rd_pend_r   <= rd_pend_nxt;
      out_valid_r <= out_valid_nxt;
      div_go_r    <= (state_r == S_IDLE) && (state_nxt == S_DIV);
      if (state_r == S_CLEAR && ra == WADDR_W'(NUM_WORDS - 1)) boot_r <= 1'b0;
    end
    any_r  <= any_nxt;
    all_r  <= all_nxt;
    res_r  <= res_nxt;
    prod_r <= 17'(alloc_idx) * 17'(eff_size);
    if (in_ch.valid && in_ch.ready) begin
      op_r   <= in_ch.data.operation;
      goff_r <= in_ch.data.granule_offset;
    end
    if (state_r == S_DIV && div_done) qidx_r <= quot;
    else if (state_r == S_IDLE) qidx_r <= '0;
  end

  // A result is never offered while a new transaction can be accepted.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ch.ready) else $error("accept while result pending");
  // A stalled result holds its payload.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |=> $stable(res_r)) else $error("result changed");
  // Alloc success never reports a block at or above the usable count.
  a_alloc_rng: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && op_r == OP_ALLOC && res_r.ok |->
      (BIDX_W+1)'(res_r.block_index) < usable) else $error("alloc out of range");
endmodule

[test/pbba_checker.sv]
// Checker for the page block bitmap allocator: models the bitmaps and compares every result.
`timescale 1ns / 100ps
module pbba_checker import pbba_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  in_item_t              in_data,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int                    fail_count,
  output int                    outstanding,
  output int                    result_count
);

  // Model copy of the page state and the configuration.
  logic              used_map [MAX_BLOCKS];
  logic              mark_map [MAX_BLOCKS];
  logic [CNT_W-1:0]  blk_count;
  logic [SIZE_W-1:0] blk_size;
  out_item_t         result_q [$];

  // Works out the result of one operation and updates the page state.
  function automatic out_item_t page_op(in_item_t it);
    out_item_t r;
    int        cnt;
    int        sz;
    int        idx;
    bit        any_live;
    bit        all_live;
    r   = '0;
    cnt = (blk_count > MAX_BLOCKS) ? MAX_BLOCKS : int'(blk_count);
    sz  = (blk_size == 0) ? 1 : int'(blk_size);
    case (it.operation)
      OP_INIT: begin
        for (int i = 0; i < MAX_BLOCKS; i++) begin
          used_map[i] = 1'b0;
          mark_map[i] = 1'b0;
        end
      end
      OP_ALLOC: begin
        for (int i = 0; i < cnt; i++) begin
          if (!used_map[i]) begin
            used_map[i]    = 1'b1;
            r.ok           = 1'b1;
            r.block_index  = i[BIDX_W-1:0];
            r.block_offset = OFF_W'(i * sz);
            break;
          end
        end
      end
      OP_TMARK, OP_UNMRK, OP_TEST: begin
        idx           = int'(it.granule_offset) / sz;
        r.block_index = idx[BIDX_W-1:0];
        if (idx < cnt) begin
          r.was_marked = mark_map[idx];
          if (it.operation == OP_TMARK) mark_map[idx] = 1'b1;
          else if (it.operation == OP_UNMRK) mark_map[idx] = 1'b0;
        end
      end
      OP_SWEEP: begin
        any_live = 1'b0;
        all_live = (cnt > 0);
        for (int i = 0; i < MAX_BLOCKS; i++) begin
          used_map[i] = mark_map[i];
          if (i < cnt) begin
            if (mark_map[i]) any_live = 1'b1;
            else all_live = 1'b0;
          end
          mark_map[i] = 1'b0;
        end
        r.ok        = any_live;
        r.page_full = any_live && all_live;
      end
      default: begin
      end
    endcase
    return r;
  endfunction

  // Tracks register writes, predicts on each input transaction and checks each result.
  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < MAX_BLOCKS; i++) begin
        used_map[i] = 1'b0;
        mark_map[i] = 1'b0;
      end
      blk_count    = CNT_W'(1024);
      blk_size     = SIZE_W'(1);
      result_q     = {};
      fail_count   <= 0;
      result_count <= 0;
      outstanding  <= 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BLOCK_COUNT) blk_count = cfg_data[CNT_W-1:0];
        else if (cfg_index == REG_BLOCK_SIZE) blk_size = cfg_data[SIZE_W-1:0];
      end
      if (in_valid && in_ready) result_q.push_back(page_op(in_data));
      if (out_valid && out_ready) begin
        result_count <= result_count + 1;
        if (result_q.size() == 0) begin
          $error("result transaction with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          want = result_q.pop_front();
          if (want != out_data) fail_count <= fail_count + 1;
          if (want.ok != out_data.ok)
            $error("ok: expected %0d, got %0d", want.ok, out_data.ok);
          if (want.block_index != out_data.block_index)
            $error("block_index: expected %0d, got %0d", want.block_index,
                   out_data.block_index);
          if (want.block_offset != out_data.block_offset)
            $error("block_offset: expected %0d, got %0d", want.block_offset,
                   out_data.block_offset);
          if (want.was_marked != out_data.was_marked)
            $error("was_marked: expected %0d, got %0d", want.was_marked,
                   out_data.was_marked);
          if (want.page_full != out_data.page_full)
            $error("page_full: expected %0d, got %0d", want.page_full,
                   out_data.page_full);
        end
      end
      outstanding <= result_q.size();
    end
  end

endmodule

[test/tb_page_block_bitmap_allocator.sv]
// Top of the allocator testbench: clock, reset, stimulus, stalls and the verdict.
`timescale 1ns / 100ps
module tb_page_block_bitmap_allocator;
  import pbba_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam int LONG_HOLD   = 250;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    fail_count;
  int                    outstanding;
  int                    result_count;
  int                    sent_count;
  int                    idle_cycles;
  bit                    quiet;
  bit                    hold_go;
  bit                    hold_done;

  pbba_if #(.payload_t(in_item_t))  in_ch  ();
  pbba_if #(.payload_t(out_item_t)) out_ch ();

  page_block_bitmap_allocator DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  pbba_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_ready    (in_ch.ready),
    .in_data     (in_ch.data),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_data    (out_ch.data),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .fail_count  (fail_count),
    .outstanding (outstanding),
    .result_count(result_count)
  );

  // Clock generation.
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Result side: random stall bursts, one long hold-off, steady ready when quiet.
  initial begin
    out_ch.ready <= 1'b0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ch.ready <= 1'b0;
        repeat ($urandom_range(0, 7)) @(posedge clk);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offers one transaction and waits until the block takes it.
  task automatic send(logic [OP_W-1:0] op, logic [GOFF_W-1:0] goff);
    in_item_t it;
    it.operation      = op;
    it.granule_offset = goff;
    in_ch.valid <= 1'b1;
    in_ch.data  <= it;
    do @(posedge clk); while (!in_ch.ready);
    sent_count++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Waits until every expected result is back, then writes both registers.
  task automatic set_page(int unsigned cnt, int unsigned size);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_BLOCK_COUNT;
    cfg_data  <= CFG_DATA_W'(cnt);
    @(posedge clk);
    cfg_index <= REG_BLOCK_SIZE;
    cfg_data  <= CFG_DATA_W'(size);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Random traffic, mostly allocate / mark / sweep cycles with offsets near real blocks.
  task automatic random_items(int n, int unsigned cnt, int unsigned size);
    int unsigned pick;
    int unsigned sz;
    int unsigned lim;
    logic [GOFF_W-1:0] goff;
    sz  = (size == 0) ? 1 : size;
    lim = (cnt > 1024) ? 1024 : ((cnt == 0) ? 1 : cnt);
    for (int k = 0; k < n; k++) begin
      pick = $urandom_range(0, 99);
      if ($urandom_range(0, 4) == 0) goff = GOFF_W'($urandom);
      else goff = GOFF_W'($urandom_range(0, lim - 1) * sz + $urandom_range(0, sz - 1));
      if (pick < 35)      send(OP_ALLOC, goff);
      else if (pick < 60) send(OP_TMARK, goff);
      else if (pick < 68) send(OP_UNMRK, goff);
      else if (pick < 80) send(OP_TEST, goff);
      else if (pick < 92) send(OP_SWEEP, goff);
      else if (pick < 95) send(OP_INIT, goff);
      else send(($urandom_range(0, 1) == 0) ? OP_RSVD6 : OP_RSVD7, goff);
    end
  endtask

  // Stimulus: directed cases, then random phases over several page shapes.
  initial begin
    rst_n       = 1'b0;
    cfg_we      = 1'b0;
    cfg_index   = REG_BLOCK_COUNT;
    cfg_data    = '0;
    in_ch.valid = 1'b0;
    in_ch.data  = '0;
    sent_count  = 0;
    quiet       = 1'b0;
    hold_go     = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: tiny page filled, marked, swept to full and to empty.
    set_page(4, 3);
    send(OP_ALLOC, 0); send(OP_ALLOC, 0); send(OP_ALLOC, 0); send(OP_ALLOC, 0);
    send(OP_ALLOC, 0);
    send(OP_TMARK, 0); send(OP_TMARK, 4); send(OP_TMARK, 8); send(OP_TMARK, 11);
    send(OP_TMARK, 11); send(OP_TEST, 12); send(OP_UNMRK, 1023);
    send(OP_SWEEP, 0); send(OP_ALLOC, 0); send(OP_SWEEP, 0);
    send(OP_RSVD6, 10'h3ff); send(OP_RSVD7, 10'h155); send(OP_INIT, 0);
    // Directed: no usable block, oversized count, zero and widest block sizes.
    set_page(0, 0);
    send(OP_ALLOC, 0); send(OP_TMARK, 0); send(OP_SWEEP, 0);
    set_page(2047, 127);
    send(OP_ALLOC, 0); send(OP_TMARK, 10'h3ff); send(OP_TEST, 10'h3ff);
    send(OP_UNMRK, 10'h2aa);

    // Random phases; the receiver holds off once while the sender keeps going.
    set_page(1024, 1);
    hold_go = 1'b1;
    random_items(150, 1024, 1);
    set_page(1, 1);
    random_items(150, 1, 1);
    set_page(8, 124);
    random_items(250, 8, 124);
    set_page(1024, 124);
    random_items(125, 1024, 124);
    set_page(37, 0);
    random_items(200, 37, 0);
    set_page(1024, 1);
    for (int k = 0; k < 100; k++) send(OP_ALLOC, 0);
    random_items(150, 1024, 1);
    set_page(16, 5);
    random_items(250, 16, 5);
    set_page(2047, 64);
    random_items(100, 2047, 64);
    quiet = 1'b1;
    set_page(12, 7);
    random_items(200, 12, 7);
    in_ch.valid <= 1'b0;

    // Drain and report.
    for (int w = 0; w < 20000 && outstanding != 0; w++) @(posedge clk);
    repeat (60) @(posedge clk);
    $display("Sent %0d operations over eleven page shapes, %0d results checked.",
             sent_count, result_count);
    $display("Covered alloc to full, mark/unmark/test, sweeps, init and unused codes.");
    if (fail_count == 0 && outstanding == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/pbba_pkg.sv
rtl/core/pbba_if.sv
rtl/core/pbba_div.sv
rtl/core/page_block_bitmap_allocator.sv
test/pbba_checker.sv
test/tb_page_block_bitmap_allocator.sv
